>>> rtl/gapfree_core_region_finder_top_assert.svh
// Assertion macros shared by the gap-free core region finder modules.
`ifndef GAPFREE_CORE_REGION_FINDER_TOP_ASSERT_SVH
`define GAPFREE_CORE_REGION_FINDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GCRF_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gcrf: invariant violated");
`define GCRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcrf: sequence check violated");
`else
`define GCRF_ASSERT_ALWAYS(label, clk, rst, expr)
`define GCRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/gcrf_pkg.sv
// Types and constants of the gap-free core region finder.
package gcrf_pkg;

  localparam int SEQ_LANES = 32;
  localparam int RES_DEPTH = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CORE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SEQS  = 2'd1;

  localparam logic ITEM_REGION  = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  typedef struct packed {
    logic [31:0] gap_mask;
    logic        last_column;
  } column_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] region_begin;
    logic [15:0] region_end;
    logic [15:0] region_total;
    logic        final_item;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } gcrf_push_t;

endpackage

>>> rtl/gapfree_core_region_finder_top.sv
// Top level of the gap-free core region finder.
//
//   Channel  Direction  Handshake                Payload
//   column   in         column_valid/ready       column_t  (gap mask, last column flag)
//   result   out        result_valid/ready       result_t  (region report or summary)
//   cfg      in         cfg_valid/ready          cfg_index, cfg_data
//
// One column request is taken per clock cycle while the tracker is not stalled. A
// taken column sits in an input register, where a lane reduction and the run tracker
// turn it into zero, one or two results that are written into a four-entry result queue.
// The tracker advances only while the queue has room for two results, so a stall
// on the result side backs up into the input register and then into column_ready.
// Reset is synchronous and returns the registers to min_core_len 4 and
// active_seqs 32 and starts a fresh alignment; there is no clearing pass.
module gapfree_core_region_finder_top import gcrf_pkg::*; #(
  parameter int MAX_COLUMNS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 column_valid,
  output logic                 column_ready,
  input  column_t              column,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // Configuration registers.
  logic [7:0] min_core_len;
  logic [5:0] active_seqs;

  // Input register holding the column being processed.
  logic    hold_valid;
  column_t hold_col;

  logic       advance;
  logic       room2;
  logic       any_gap;
  gcrf_push_t push;

  // The tracker consumes the held column once the queue can take both results
  // it might produce; a new column is taken in the same cycle.
  assign advance      = hold_valid && room2;
  assign column_ready = !hold_valid || advance;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_core_len <= 8'd4;
      active_seqs  <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_CORE_LEN: min_core_len <= cfg_data;
        REG_ACTIVE_SEQS:  active_seqs  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (column_ready) begin
      hold_valid <= column_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (column_valid && column_ready) begin
      hold_col <= column;
    end
  end

  gcrf_lane_check u_lane_check (
    .gap_mask    (hold_col.gap_mask),
    .active_seqs (active_seqs),
    .any_gap     (any_gap)
  );

  gcrf_region_tracker #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .any_gap      (any_gap),
    .last_column  (hold_col.last_column),
    .min_core_len (min_core_len),
    .push         (push)
  );

  gcrf_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule

>>> rtl/gcrf_lane_check.sv
// Masked OR reduction that decides whether a column holds a gap.
module gcrf_lane_check import gcrf_pkg::*; (
  input  logic [SEQ_LANES-1:0] gap_mask,
  input  logic [5:0]           active_seqs,
  output logic                 any_gap
);

  logic [SEQ_LANES-1:0] lane_mask;

  // Lane j is checked when it lies below the active sequence count.
  always_comb begin
    for (int j = 0; j < SEQ_LANES; j++) begin
      lane_mask[j] = (active_seqs > 6'(j));
    end
  end

  assign any_gap = |(gap_mask & lane_mask);

endmodule

>>> rtl/gcrf_region_tracker.sv
// Column state tracking and region report generation.
`include "gapfree_core_region_finder_top_assert.svh"
module gcrf_region_tracker import gcrf_pkg::*; #(
  parameter int MAX_COLUMNS = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       any_gap,
  input  logic       last_column,
  input  logic [7:0] min_core_len,
  output gcrf_push_t push
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);

  logic [COL_W-1:0] column_index, column_index_next;
  logic [COL_W-1:0] core_run_start, core_run_start_next;
  logic [COL_W-1:0] gappy_start, gappy_start_next;
  logic [7:0]       core_run_len, core_run_len_next;
  logic             gappy_open, gappy_open_next;
  logic             region_pending, region_pending_next;
  logic [15:0]      region_count, region_count_next;

  logic        demote;
  logic        emit;
  logic [15:0] count_after;
  result_t     region_item;
  result_t     summary_item;

  function automatic logic [15:0] col16(input logic [COL_W-1:0] v);
    logic [COL_W+15:0] wide;
    wide = {16'b0, v};
    return wide[15:0];
  endfunction

  always_comb begin
    column_index_next   = column_index;
    core_run_start_next = core_run_start;
    gappy_start_next    = gappy_start;
    core_run_len_next   = core_run_len;
    gappy_open_next     = gappy_open;
    region_pending_next = region_pending;
    region_count_next   = region_count;

    demote = (core_run_len != 8'd0) && (core_run_len < min_core_len);

    if (any_gap) begin
      // A short core run ended by a gap joins the region it would have closed.
      if (!gappy_open) begin
        gappy_start_next = demote ? core_run_start : column_index;
      end
      gappy_open_next     = 1'b1;
      region_pending_next = 1'b0;
      core_run_len_next   = 8'd0;
    end else begin
      if (core_run_len == 8'd0) begin
        core_run_start_next = column_index;
        if (gappy_open) begin
          region_pending_next = 1'b1;
        end
      end
      if (core_run_len != 8'hFF) begin
        core_run_len_next = core_run_len + 8'd1;
      end
    end

    emit = region_pending_next && ((core_run_len_next >= min_core_len) || last_column);
    count_after = (emit && (region_count != 16'hFFFF)) ? region_count + 16'd1
                                                        : region_count;

    region_item.item_kind    = ITEM_REGION;
    region_item.region_begin = col16(gappy_start_next);
    region_item.region_end   = col16(core_run_start_next);
    region_item.region_total = 16'd0;
    region_item.final_item   = 1'b0;

    summary_item.item_kind    = ITEM_SUMMARY;
    summary_item.region_begin = 16'd0;
    summary_item.region_end   = 16'd0;
    summary_item.region_total = count_after;
    summary_item.final_item   = 1'b1;

    if (emit) begin
      gappy_open_next     = 1'b0;
      region_pending_next = 1'b0;
      region_count_next   = count_after;
    end

    if (last_column) begin
      column_index_next   = '0;
      core_run_start_next = '0;
      gappy_start_next    = '0;
      core_run_len_next   = 8'd0;
      gappy_open_next     = 1'b0;
      region_pending_next = 1'b0;
      region_count_next   = 16'd0;
    end else begin
      column_index_next = (column_index == COL_LAST) ? '0 : column_index + 1'b1;
    end

    push.count = step ? ({1'b0, emit} + {1'b0, last_column}) : 2'd0;
    push.slot0 = emit ? region_item : summary_item;
    push.slot1 = summary_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      core_run_start <= '0;
      gappy_start    <= '0;
      core_run_len   <= 8'd0;
      gappy_open     <= 1'b0;
      region_pending <= 1'b0;
      region_count   <= 16'd0;
    end else if (step) begin
      column_index   <= column_index_next;
      core_run_start <= core_run_start_next;
      gappy_start    <= gappy_start_next;
      core_run_len   <= core_run_len_next;
      gappy_open     <= gappy_open_next;
      region_pending <= region_pending_next;
      region_count   <= region_count_next;
    end
  end

  `GCRF_ASSERT_ALWAYS(a_pending_needs_open, clk, rst, !region_pending || gappy_open)
  `GCRF_ASSERT_NEXT(a_last_clears, clk, rst, step && last_column,
    (column_index == '0) && !gappy_open && (region_count == 16'd0))
  `GCRF_ASSERT_ALWAYS(a_two_only_at_end, clk, rst, (push.count != 2'd2) || (step && last_column))

endmodule

>>> rtl/gcrf_result_fifo.sv
// Small result queue taking up to two requests per cycle and giving one while out_ready is high.
`include "gapfree_core_region_finder_top_assert.svh"
module gcrf_result_fifo import gcrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  gcrf_push_t push,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  result_t            mem [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign room2     = (count <= CNT_W'(RES_DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  `GCRF_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(RES_DEPTH))
  `GCRF_ASSERT_ALWAYS(a_no_overflow, clk, rst,
    (push.count == 2'd0) || (CNT_W'(push.count) <= CNT_W'(RES_DEPTH) - count))
  `GCRF_ASSERT_NEXT(a_pop_drains, clk, rst, pop && (push.count == 2'd0),
    count == $past(count) - 1'b1)

endmodule
